### design/blc_pkg.sv
// package: constants, types and opcodes for boundary loop clustering
package blc_pkg;

   localparam int MaxPoints = 4096;
   localparam int MaxEdges  = 1024;
   localparam int MaxLoops  = 64;

   localparam int PtW   = 13;
   localparam int PaW   = $clog2(MaxPoints);
   localparam int EaW   = $clog2(MaxEdges);
   localparam int EcW   = $clog2(MaxEdges + 1);
   localparam int LpW   = $clog2(MaxLoops);
   localparam int ElemW = 20;
   localparam int SumW  = 32 + EcW;

   localparam logic [2:0] OP_LOAD_POINT = 3'd0;
   localparam logic [2:0] OP_LOAD_ELEM  = 3'd1;
   localparam logic [2:0] OP_RUN        = 3'd2;
   localparam logic [2:0] OP_READ_LABEL = 3'd3;
   localparam logic [2:0] OP_READ_LOOP  = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_NO_EDGE  = 2'd2;
   localparam logic [1:0] ST_BAD      = 2'd3;

   typedef struct packed {
      logic [2:0]        operation;
      logic [12:0]       slot;
      logic [19:0]       element_number;
      logic              element_open;
      logic [12:0]       vertex_a;
      logic [12:0]       vertex_b;
      logic [12:0]       vertex_c;
      logic [2:0]        free_edge_mask;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic signed [31:0] coord_z;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [5:0]         loop_count;
      logic [10:0]        edge_count;
      logic [19:0]        element_out;
      logic [5:0]         loop_label;
      logic [10:0]        point_count;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE, S_LOAD, S_READ_WAIT, S_READ_DONE,
      S_CLR, S_SEED_RD, S_SEED_CHK, S_Q_RD, S_Q_WAIT, S_SCAN_RD, S_SCAN_CHK,
      S_SUM_RD, S_SUM_WAIT, S_SUM_ACC, S_DIV, S_STORE, S_RUN_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic read_issue;
      logic respond;
      logic clr_step;
      logic clr_init;
      logic seed_rd;
      logic seed_skip;
      logic seed_take;
      logic q_latch;
      logic scan_rd;
      logic scan_take;
      logic sum_init;
      logic sum_rd;
      logic sum_acc;
      logic div_start;
      logic store;
      logic overflow;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic seed_unlabeled;
      logic seed_last;
      logic loops_full;
      logic q_last;
      logic scan_last;
      logic sum_last;
      logic div_done;
   } sts_type;

endpackage

### design/boundary_loop_clustering.sv
// top level: boundary edge loop clustering engine
//  channel   ports                        handshake
//  request   start, busy, req_payload      taken when start && !busy
//  response  rsp_strobe, rsp_payload       one cycle, no backpressure
// loads write in S_LOAD; reads issue in S_READ_WAIT and answer in S_READ_DONE via registered read ports
// a run clears labels, checks each seed edge, scans every edge for each queued point,
// and per loop sums its points, runs the parallel dividers and stores the result
// synchronous reset clears control and counters only, not the memories
module boundary_loop_clustering (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  blc_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output blc_pkg::rsp_type rsp_payload
);
   import blc_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    accept;

   assign accept = start && !busy;

   blc_ctrl u_ctrl (.clock, .reset, .start_accept(accept),
                    .operation(req_payload.operation), .sts, .cmd, .busy);

   blc_datapath u_dp (.clock, .reset, .start_accept(accept), .req(req_payload),
                      .cmd, .sts, .rsp_strobe_out(rsp_strobe), .rsp_out(rsp_payload));

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy) else $error("busy not raised");
   a_no_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !$past(accept)) else $error("response too early");
`endif

endmodule

### design/blc_div.sv
// restoring divider: signed sum over unsigned count, truncating toward zero
module blc_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [blc_pkg::SumW-1:0] dividend,
   input  logic [blc_pkg::EcW-1:0]      divisor,
   output logic                         done,
   output logic signed [31:0]           quotient
);
   import blc_pkg::*;

   localparam int CntW = $clog2(SumW + 1);

   logic [SumW-1:0] q_ff, q_in;
   logic [EcW:0]    r_ff, r_in;
   logic [EcW-1:0]  d_ff, d_in;
   logic            neg_ff, neg_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [EcW:0]    trial;
   logic [SumW-1:0] qn;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff[EcW-1:0], q_ff[SumW-1]};
      if (start) begin
         neg_in  = dividend[SumW-1];
         q_in    = dividend[SumW-1] ? SumW'(-dividend) : SumW'(dividend);
         r_in    = '0;
         d_in    = divisor;
         cnt_in  = CntW'(SumW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[SumW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[SumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      neg_ff <= neg_in;
   end

   assign qn       = neg_ff ? SumW'(-q_ff) : q_ff;
   assign quotient = qn[31:0];
   assign done     = done_ff;

endmodule

### design/blc_datapath.sv
// datapath: point, edge, queue and loop stores with the run counters
module blc_datapath (
   input  logic             clock,
   input  logic             reset,
   input  logic             start_accept,
   input  blc_pkg::req_type req,
   input  blc_pkg::cmd_type cmd,
   output blc_pkg::sts_type sts,
   output logic             rsp_strobe_out,
   output blc_pkg::rsp_type rsp_out
);
   import blc_pkg::*;

   logic signed [31:0] px_mem [MaxPoints];
   logic signed [31:0] py_mem [MaxPoints];
   logic signed [31:0] pz_mem [MaxPoints];
   logic [ElemW-1:0]   ee_mem [MaxEdges];
   logic [PtW-1:0]     ea_mem [MaxEdges];
   logic [PtW-1:0]     eb_mem [MaxEdges];
   logic [LpW-1:0]     el_mem [MaxEdges];
   logic [PtW-1:0]     q_mem  [MaxEdges];
   logic signed [31:0] cx_mem [MaxLoops];
   logic signed [31:0] cy_mem [MaxLoops];
   logic signed [31:0] cz_mem [MaxLoops];
   logic [EcW-1:0]     ls_mem [MaxLoops];

   req_type        req_ff;
   logic [EcW-1:0] ecnt_ff, ecnt_in;
   logic [LpW-1:0] loops_ff;
   logic [LpW-1:0] idx_ff;
   logic [1:0]     rstat_ff;
   logic [EcW-1:0] i_ff, k_ff, j_ff, n_ff;
   logic [PtW-1:0] pt_ff;
   logic [ElemW-1:0] rd_e_ff;
   logic [PtW-1:0] rd_a_ff, rd_b_ff;
   logic [LpW-1:0] rd_l_ff;
   logic [PtW-1:0] rd_q_ff;
   logic signed [31:0] rx_ff, ry_ff, rz_ff;
   logic [EcW-1:0] rs_ff;
   logic           qok_ff;
   logic signed [SumW-1:0] sx_ff, sy_ff, sz_ff;
   logic signed [31:0] dqx, dqy, dqz;
   logic           dvx, dvy, dvz;
   logic           rsp_v_ff;
   rsp_type        rsp_ff, rsp_in;
   logic           pt_ok_ld, slot_edge_ok, slot_loop_ok;
   logic [EaW-1:0] e_addr;
   logic [PtW-1:0] a_sel, b_sel;
   logic           e_wr, hit_a, hit_b;

   always_ff @(posedge clock) begin
      if (start_accept) req_ff <= req;
   end

   assign pt_ok_ld = (req_ff.slot != '0) && ({1'b0, req_ff.slot} <= 14'(MaxPoints));
   assign slot_edge_ok = {1'b0, req_ff.slot} < 14'(ecnt_ff);
   assign slot_loop_ok = (req_ff.slot != '0) && (req_ff.slot <= 13'(loops_ff));

   always_comb begin
      if (req_ff.free_edge_mask[2]) begin
         a_sel = req_ff.vertex_a; b_sel = req_ff.vertex_c;
      end else if (req_ff.free_edge_mask[1]) begin
         a_sel = req_ff.vertex_b; b_sel = req_ff.vertex_c;
      end else begin
         a_sel = req_ff.vertex_a; b_sel = req_ff.vertex_b;
      end
   end

   // edge table port: single address per cycle
   always_comb begin
      e_addr = ecnt_ff[EaW-1:0];
      if (cmd.read_issue)   e_addr = req_ff.slot[EaW-1:0];
      else if (cmd.seed_rd) e_addr = i_ff[EaW-1:0];
      else if (cmd.scan_rd) e_addr = k_ff[EaW-1:0];
   end

   assign e_wr = cmd.load && req_ff.operation == OP_LOAD_ELEM && req_ff.element_open
                 && req_ff.free_edge_mask != '0 && ecnt_ff < EcW'(MaxEdges);

   always_ff @(posedge clock) begin
      if (e_wr) begin
         ee_mem[e_addr] <= req_ff.element_number;
         ea_mem[e_addr] <= a_sel;
         eb_mem[e_addr] <= b_sel;
      end
      rd_e_ff <= ee_mem[e_addr];
      rd_a_ff <= ea_mem[e_addr];
      rd_b_ff <= eb_mem[e_addr];
   end

   // labels: own memory, read at e_addr, written by edge load, clear, seed and scan
   logic           l_we;
   logic [EaW-1:0] l_waddr;
   logic [LpW-1:0] l_wdata;
   always_comb begin
      l_we = 1'b0; l_waddr = i_ff[EaW-1:0]; l_wdata = '0;
      if (e_wr) begin
         l_we = 1'b1; l_waddr = e_addr;
      end else if (cmd.clr_step) begin
         l_we = 1'b1; l_waddr = i_ff[EaW-1:0];
      end else if (cmd.seed_take) begin
         l_we = 1'b1; l_waddr = i_ff[EaW-1:0]; l_wdata = loops_ff + 1'b1;
      end else if (cmd.scan_take && (hit_a || hit_b)) begin
         l_we = 1'b1; l_waddr = k_ff[EaW-1:0]; l_wdata = idx_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (l_we) el_mem[l_waddr] <= l_wdata;
      rd_l_ff <= el_mem[e_addr];
   end

   assign hit_a = rd_l_ff == '0 && rd_a_ff == pt_ff;
   assign hit_b = rd_l_ff == '0 && rd_b_ff == pt_ff;

   // walk queue
   logic           q_we;
   logic [PtW-1:0] q_wdata;
   logic [EaW-1:0] q_waddr;
   logic [EcW-1:0] q_raddr;
   always_comb begin
      q_we = 1'b0; q_wdata = rd_a_ff;
      q_waddr = cmd.seed_take ? '0 : n_ff[EaW-1:0];
      if (cmd.seed_take) q_we = 1'b1;
      else if (cmd.scan_take && n_ff < EcW'(MaxEdges)) begin
         if (hit_a)      begin q_we = 1'b1; q_wdata = rd_b_ff; end
         else if (hit_b) begin q_we = 1'b1; q_wdata = rd_a_ff; end
      end
      q_raddr = j_ff;
   end
   always_ff @(posedge clock) begin
      if (q_we) q_mem[q_waddr] <= q_wdata;
      rd_q_ff <= q_mem[q_raddr[EaW-1:0]];
   end

   // points
   logic [PaW-1:0] p_addr;
   logic           q_ok;
   assign q_ok   = rd_q_ff != '0 && {1'b0, rd_q_ff} <= 14'(MaxPoints);
   assign p_addr = cmd.load ? PaW'(req_ff.slot - 1'b1) : PaW'(rd_q_ff - 1'b1);
   always_ff @(posedge clock) begin
      if (cmd.load && req_ff.operation == OP_LOAD_POINT && pt_ok_ld) begin
         px_mem[p_addr] <= req_ff.coord_x;
         py_mem[p_addr] <= req_ff.coord_y;
         pz_mem[p_addr] <= req_ff.coord_z;
      end
      rx_ff  <= px_mem[p_addr];
      ry_ff  <= py_mem[p_addr];
      rz_ff  <= pz_mem[p_addr];
      qok_ff <= q_ok;
   end

   // loop stores
   logic [LpW-1:0] lp_raddr;
   logic signed [31:0] rcx_ff, rcy_ff, rcz_ff;
   assign lp_raddr = req_ff.slot[LpW-1:0];
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         cx_mem[idx_ff] <= dqx;
         cy_mem[idx_ff] <= dqy;
         cz_mem[idx_ff] <= dqz;
         ls_mem[idx_ff] <= n_ff;
      end
      rcx_ff <= cx_mem[lp_raddr];
      rcy_ff <= cy_mem[lp_raddr];
      rcz_ff <= cz_mem[lp_raddr];
      rs_ff  <= ls_mem[lp_raddr];
   end

   blc_div u_div_x (.clock, .reset, .start(cmd.div_start), .dividend(sx_ff),
                    .divisor(n_ff), .done(dvx), .quotient(dqx));
   blc_div u_div_y (.clock, .reset, .start(cmd.div_start), .dividend(sy_ff),
                    .divisor(n_ff), .done(dvy), .quotient(dqy));
   blc_div u_div_z (.clock, .reset, .start(cmd.div_start), .dividend(sz_ff),
                    .divisor(n_ff), .done(dvz), .quotient(dqz));

   // run counters
   always_ff @(posedge clock) begin
      if (reset) begin
         ecnt_ff  <= '0;
         loops_ff <= '0;
         i_ff <= '0; j_ff <= '0; k_ff <= '0; n_ff <= '0;
         idx_ff <= '0; rstat_ff <= ST_OK;
      end else begin
         ecnt_ff <= ecnt_in;
         if (cmd.clr_init) begin
            i_ff <= '0; rstat_ff <= ST_OK; loops_ff <= '0;
         end
         if (cmd.clr_step) i_ff <= (i_ff + 1'b1 == ecnt_ff) ? '0 : i_ff + 1'b1;
         if (cmd.seed_skip) i_ff <= i_ff + 1'b1;
         if (cmd.seed_take) begin
            idx_ff <= loops_ff + 1'b1;
            n_ff <= EcW'(1);
            j_ff <= '0;
         end
         if (cmd.q_latch) pt_ff <= rd_q_ff;
         if (cmd.q_latch) k_ff <= '0;
         if (cmd.scan_take) begin
            k_ff <= k_ff + 1'b1;
            if ((hit_a || hit_b) && n_ff < EcW'(MaxEdges)) n_ff <= n_ff + 1'b1;
            if (k_ff + 1'b1 == ecnt_ff) j_ff <= j_ff + 1'b1;
         end
         if (cmd.sum_init) j_ff <= '0;
         if (cmd.sum_rd) j_ff <= j_ff + 1'b1;
         if (cmd.store) begin
            loops_ff <= idx_ff;
            i_ff <= i_ff + 1'b1;
         end
         if (cmd.overflow) rstat_ff <= ST_BAD;
      end
   end

   always_comb begin
      ecnt_in = ecnt_ff;
      if (e_wr) ecnt_in = ecnt_ff + 1'b1;
   end

   // sums (each sum_rd is tracked through sacc_ff and sacc2_ff, behind the queue and point reads, then accumulated)
   logic sacc_ff, sacc2_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         sacc_ff <= 1'b0; sacc2_ff <= 1'b0;
      end else begin
         sacc_ff <= cmd.sum_rd; sacc2_ff <= sacc_ff;
      end
      if (cmd.sum_init) begin
         sx_ff <= '0; sy_ff <= '0; sz_ff <= '0;
      end else if (sacc2_ff && qok_ff) begin
         sx_ff <= sx_ff + SumW'(rx_ff);
         sy_ff <= sy_ff + SumW'(ry_ff);
         sz_ff <= sz_ff + SumW'(rz_ff);
      end
   end

   assign sts.clr_last       = (i_ff + 1'b1 >= ecnt_ff);
   assign sts.seed_unlabeled = rd_l_ff == '0;
   assign sts.seed_last      = i_ff >= ecnt_ff;
   assign sts.loops_full     = loops_ff >= LpW'(MaxLoops - 1);
   assign sts.q_last         = j_ff >= n_ff;
   assign sts.scan_last      = k_ff + 1'b1 == ecnt_ff;
   assign sts.sum_last       = j_ff >= n_ff && !sacc_ff && !sacc2_ff;
   assign sts.div_done       = dvx & dvy & dvz;

   // response
   always_comb begin
      rsp_in = '0;
      rsp_in.loop_count = loops_ff;
      rsp_in.edge_count = ecnt_ff;
      unique case (req_ff.operation)
         OP_LOAD_POINT: rsp_in.status = pt_ok_ld ? ST_OK : ST_BAD;
         OP_LOAD_ELEM: begin
            if (!req_ff.element_open)          rsp_in.status = ST_OK;
            else if (req_ff.free_edge_mask == '0) rsp_in.status = ST_NO_EDGE;
            else if (ecnt_ff >= EcW'(MaxEdges))  rsp_in.status = ST_FULL;
            else                                  rsp_in.status = ST_OK;
            rsp_in.edge_count = ecnt_in;
         end
         OP_RUN: rsp_in.status = rstat_ff;
         OP_READ_LABEL: begin
            if (slot_edge_ok) begin
               rsp_in.element_out = rd_e_ff;
               rsp_in.loop_label  = rd_l_ff;
            end else rsp_in.status = ST_BAD;
         end
         OP_READ_LOOP: begin
            if (slot_loop_ok) begin
               rsp_in.point_count = rs_ff;
               rsp_in.center_x = rcx_ff;
               rsp_in.center_y = rcy_ff;
               rsp_in.center_z = rcz_ff;
            end else rsp_in.status = ST_BAD;
         end
         default: rsp_in.status = ST_BAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_v_ff <= 1'b0;
      else       rsp_v_ff <= cmd.respond;
      if (cmd.respond) rsp_ff <= rsp_in;
   end

   assign rsp_strobe_out = rsp_v_ff;
   assign rsp_out        = rsp_ff;

endmodule

### design/blc_ctrl.sv
// controller: sequences loads, reads and the clustering run
module blc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start_accept,
   input  logic [2:0]       operation,
   input  blc_pkg::sts_type sts,
   output blc_pkg::cmd_type cmd,
   output logic             busy
);
   import blc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start_accept) begin
               if (operation == OP_RUN) begin
                  cmd.clr_init = 1'b1; state_in = S_CLR;
               end else if (operation == OP_READ_LABEL || operation == OP_READ_LOOP)
                  state_in = S_READ_WAIT;
               else                                               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1; cmd.respond = 1'b1; state_in = S_IDLE;
         end
         S_READ_WAIT: begin
            cmd.read_issue = 1'b1; state_in = S_READ_DONE;
         end
         S_READ_DONE: begin
            cmd.respond = 1'b1; state_in = S_IDLE;
         end
         S_CLR: begin
            if (sts.seed_last) begin
               state_in = S_SEED_RD;
            end else begin
               cmd.clr_step = 1'b1;
               if (sts.clr_last) state_in = S_SEED_RD;
            end
         end
         S_SEED_RD: begin
            if (sts.seed_last) state_in = S_RUN_DONE;
            else begin
               cmd.seed_rd = 1'b1; state_in = S_SEED_CHK;
            end
         end
         S_SEED_CHK: begin
            if (!sts.seed_unlabeled) begin
               cmd.seed_skip = 1'b1; state_in = S_SEED_RD;
            end else if (sts.loops_full) begin
               cmd.overflow = 1'b1; state_in = S_RUN_DONE;
            end else begin
               cmd.seed_take = 1'b1; state_in = S_Q_RD;
            end
         end
         S_Q_RD: begin
            if (sts.q_last) begin
               cmd.sum_init = 1'b1; state_in = S_SUM_RD;
            end else begin
               state_in = S_Q_WAIT;
            end
         end
         S_Q_WAIT: begin
            cmd.q_latch = 1'b1; state_in = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            cmd.scan_rd = 1'b1; state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            cmd.scan_take = 1'b1;
            state_in = sts.scan_last ? S_Q_RD : S_SCAN_RD;
         end
         S_SUM_RD: begin
            if (sts.sum_last) begin
               cmd.div_start = 1'b1; state_in = S_DIV;
            end else if (!sts.q_last) cmd.sum_rd = 1'b1;
         end
         S_SUM_WAIT, S_SUM_ACC: state_in = S_SUM_RD;
         S_DIV: if (sts.div_done) state_in = S_STORE;
         S_STORE: begin
            cmd.store = 1'b1; state_in = S_SEED_RD;
         end
         S_RUN_DONE: begin
            cmd.respond = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = state_ff != S_IDLE;

endmodule
